@@ rtl/lbhg_pkg.sv @@
// Shared types, constants and register codes of the load-based core hotplug governor.
package lbhg_pkg;

    // Counter arithmetic width (all 64 bits of each counter are used)
    localparam int COUNTER_WIDTH = 64;
    localparam int CNT_W         = COUNTER_WIDTH;

    // Load scaling: loads are percent, 7 bits
    localparam int              LOAD_W      = 7;
    localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;
    localparam int              SCALE_BITS  = 7;
    localparam int              DIV_STEPS   = 2 * SCALE_BITS;
    localparam int              STEP_W      = $clog2(DIV_STEPS);

    localparam logic [21:0] FREQ_FLOOR_KHZ = 22'd200000;

    // Interval multipliers in half-second units
    localparam logic [2:0] MULT_FAST = 3'd1;
    localparam logic [2:0] MULT_SLOW = 3'd4;

    // Action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    // Hotplug modes
    localparam logic [1:0] MODE_AUTO    = 2'd0;
    localparam logic [1:0] MODE_MAN_ON  = 2'd1;
    localparam logic [1:0] MODE_MAN_OFF = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_LOW_OFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_HIGH_OFF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_OFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FREEZE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOTPLUG_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GOV_ENABLED   = 3'd7;

    typedef struct packed {
        logic [63:0] idle_count_core0;
        logic [63:0] wall_count_core0;
        logic [63:0] idle_count_core1;
        logic [63:0] wall_count_core1;
        logic        core1_online;
        logic [21:0] freq_khz;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        action;
        logic              reschedule;
        logic [2:0]        next_interval;
        logic [LOAD_W-1:0] average_load;
        logic [LOAD_W-1:0] load_core0;
        logic [LOAD_W-1:0] load_core1;
        logic              sample_valid;
    } out_item_t;

    typedef struct packed {
        logic [LOAD_W-1:0] load_low;
        logic [LOAD_W-1:0] load_high;
        logic [LOAD_W-1:0] load_low_display_off;
        logic [LOAD_W-1:0] load_high_display_off;
        logic              display_off;
        logic              decision_freeze;
        logic [1:0]        hotplug_mode;
        logic              governor_enabled;
    } cfg_t;

    // Status of one load lane toward the merge stage
    typedef struct packed {
        logic              busy;
        logic              fail;
        logic [LOAD_W-1:0] load;
    } lane_stat_t;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_CLASSIFY,
        LN_DIVIDE
    } lane_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_BUSY,
        TS_MERGE
    } top_state_t;

endpackage

@@ rtl/lbhg_lane.sv @@
// One load lane: counter deltas and bit-serial percent ratio for a single core.
module lbhg_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        commit,
    input  logic [lbhg_pkg::CNT_W-1:0]  idle_count,
    input  logic [lbhg_pkg::CNT_W-1:0]  wall_count,
    output lbhg_pkg::lane_stat_t        stat
);

    lbhg_pkg::lane_state_t state_reg, state_next;

    logic [lbhg_pkg::CNT_W-1:0]  prev_idle_reg, prev_idle_next;
    logic [lbhg_pkg::CNT_W-1:0]  prev_wall_reg, prev_wall_next;
    logic [lbhg_pkg::CNT_W-1:0]  cur_idle_reg, cur_idle_next;
    logic [lbhg_pkg::CNT_W-1:0]  cur_wall_reg, cur_wall_next;
    logic [lbhg_pkg::CNT_W-1:0]  di_reg, di_next;
    logic [lbhg_pkg::CNT_W-1:0]  dw_reg, dw_next;
    logic [lbhg_pkg::CNT_W-1:0]  d_reg, d_next;
    logic [lbhg_pkg::CNT_W-1:0]  r_reg, r_next;
    logic [lbhg_pkg::LOAD_W-1:0] q_reg, q_next;
    logic [lbhg_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        fail_reg, fail_next;
    logic [lbhg_pkg::LOAD_W-1:0] load_reg, load_next;

    logic                        trivial;
    logic                        last_step;
    logic [2:0]                  bit_idx;
    logic [lbhg_pkg::CNT_W:0]    two_r;
    logic                        ge_w;
    logic                        ge_di;

    // Early exits: wall below idle, zero wall, fully idle, never idle
    assign trivial   = (dw_reg < di_reg) || (dw_reg == '0) || (dw_reg == di_reg)
                     || (di_reg == '0);
    assign last_step = (step_reg == lbhg_pkg::STEP_W'(lbhg_pkg::DIV_STEPS - 1));
    assign bit_idx   = 3'(lbhg_pkg::SCALE_BITS - 1) - 3'(step_reg[lbhg_pkg::STEP_W-1:1]);
    assign two_r     = {r_reg, 1'b0};
    assign ge_w      = (two_r >= {1'b0, dw_reg});
    assign ge_di     = (r_reg >= di_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbhg_pkg::LN_IDLE: begin
                if (start) begin
                    state_next = lbhg_pkg::LN_CLASSIFY;
                end
            end
            lbhg_pkg::LN_CLASSIFY: begin
                state_next = trivial ? lbhg_pkg::LN_IDLE : lbhg_pkg::LN_DIVIDE;
            end
            lbhg_pkg::LN_DIVIDE: begin
                if (last_step) begin
                    state_next = lbhg_pkg::LN_IDLE;
                end
            end
            default: state_next = lbhg_pkg::LN_IDLE;
        endcase
    end

    // Datapath: deltas, classification, one half-step of the ratio per cycle
    always_comb begin
        prev_idle_next = prev_idle_reg;
        prev_wall_next = prev_wall_reg;
        cur_idle_next  = cur_idle_reg;
        cur_wall_next  = cur_wall_reg;
        di_next        = di_reg;
        dw_next        = dw_reg;
        d_next         = d_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        step_next      = step_reg;
        fail_next      = fail_reg;
        load_next      = load_reg;

        case (state_reg)
            lbhg_pkg::LN_IDLE: begin
                if (start) begin
                    cur_idle_next = idle_count;
                    cur_wall_next = wall_count;
                    di_next       = idle_count - prev_idle_reg;
                    dw_next       = wall_count - prev_wall_reg;
                end
            end
            lbhg_pkg::LN_CLASSIFY: begin
                fail_next = (dw_reg < di_reg);
                if ((dw_reg < di_reg) || (dw_reg == '0) || (dw_reg == di_reg)) begin
                    load_next = '0;
                end else if (di_reg == '0) begin
                    load_next = lbhg_pkg::LOAD_SCALE;
                end else begin
                    load_next = '0;
                end
                d_next    = dw_reg - di_reg;
                r_next    = '0;
                q_next    = '0;
                step_next = '0;
            end
            lbhg_pkg::LN_DIVIDE: begin
                if (!step_reg[0]) begin
                    // double the remainder, one quotient bit against the wall delta
                    r_next = ge_w ? lbhg_pkg::CNT_W'(two_r - {1'b0, dw_reg})
                                  : lbhg_pkg::CNT_W'(two_r);
                    q_next = {q_reg[lbhg_pkg::LOAD_W-2:0], ge_w};
                end else if (lbhg_pkg::LOAD_SCALE[bit_idx]) begin
                    // add the busy delta; overflow past the wall delta carries into q
                    r_next = ge_di ? (r_reg - di_reg) : (r_reg + d_reg);
                    q_next = q_reg + lbhg_pkg::LOAD_W'(ge_di);
                end
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    load_next = q_next;
                end
            end
            default: ;
        endcase

        // store the sampled counters once the governor accepts the sample
        if (commit) begin
            prev_idle_next = cur_idle_reg;
            prev_wall_next = cur_wall_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lbhg_pkg::LN_IDLE;
            prev_idle_reg <= '0;
            prev_wall_reg <= '0;
        end else begin
            state_reg     <= state_next;
            prev_idle_reg <= prev_idle_next;
            prev_wall_reg <= prev_wall_next;
        end
        cur_idle_reg <= cur_idle_next;
        cur_wall_reg <= cur_wall_next;
        di_reg       <= di_next;
        dw_reg       <= dw_next;
        d_reg        <= d_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        fail_reg     <= fail_next;
        load_reg     <= load_next;
    end

    assign stat.busy = (state_reg != lbhg_pkg::LN_IDLE);
    assign stat.fail = fail_reg;
    assign stat.load = load_reg;

endmodule

@@ rtl/lbhg_merge.sv @@
// Merge stage: combines the lane loads, applies modes and hysteresis, picks the interval.
module lbhg_merge (
    input  lbhg_pkg::cfg_t        cfg,
    input  logic                  online,
    input  logic [21:0]           freq_khz,
    input  logic [2:0]            mult,
    input  lbhg_pkg::lane_stat_t  lane0,
    input  lbhg_pkg::lane_stat_t  lane1,
    output lbhg_pkg::out_item_t   result,
    output logic [2:0]            mult_next
);

    logic [lbhg_pkg::LOAD_W:0]   load_sum;
    logic [lbhg_pkg::LOAD_W-1:0] avg;
    logic [lbhg_pkg::LOAD_W-1:0] thr_lo;
    logic [lbhg_pkg::LOAD_W-1:0] thr_hi;
    logic                        freq_low;

    assign load_sum = {1'b0, lane0.load} + {1'b0, lane1.load};
    assign avg      = online ? load_sum[lbhg_pkg::LOAD_W:1] : lane0.load;
    assign thr_lo   = cfg.display_off ? cfg.load_low_display_off : cfg.load_low;
    assign thr_hi   = cfg.display_off ? cfg.load_high_display_off : cfg.load_high;
    assign freq_low = (freq_khz <= lbhg_pkg::FREQ_FLOOR_KHZ);

    always_comb begin
        result    = '0;
        mult_next = mult;
        if (!cfg.governor_enabled) begin
            // stopped: no action, no loads, no reschedule
        end else if (cfg.hotplug_mode != lbhg_pkg::MODE_AUTO) begin
            if ((cfg.hotplug_mode == lbhg_pkg::MODE_MAN_OFF) && online) begin
                result.action = lbhg_pkg::ACT_DOWN;
            end
        end else if (cfg.decision_freeze) begin
            result.reschedule = 1'b1;
        end else begin
            result.reschedule = 1'b1;
            // a failing core zero drops the whole sample
            if (!lane0.fail) begin
                result.load_core0 = lane0.load;
                if (!(online && lane1.fail)) begin
                    result.load_core1   = online ? lane1.load : '0;
                    result.average_load = avg;
                    result.sample_valid = 1'b1;
                    if (online && ((avg < thr_lo) || freq_low)) begin
                        result.action = lbhg_pkg::ACT_DOWN;
                        mult_next     = lbhg_pkg::MULT_FAST;
                    end else if (!online && (avg > thr_hi) && !freq_low) begin
                        result.action = lbhg_pkg::ACT_UP;
                        mult_next     = lbhg_pkg::MULT_SLOW;
                    end
                end
            end
        end
        result.next_interval = mult_next;
    end

endmodule

@@ rtl/load_based_core_hotplug_governor.sv @@
// Top level of the load-based core hotplug governor: config, control and result register.
//
// Usage:
//   s_valid/s_ready/s_data carry one tick: cumulative idle and wall counters of both
//   cores, the online flag of core one and the current frequency. m_valid/m_ready/m_data
//   return one decision per tick: action, reschedule flag, next interval and loads.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the eight control registers; cfg_ready
//   is high out of reset and writes belong only in gaps with no tick in flight.
// Operation:
//   In automatic mode two lanes, one per core, compute the loads side by side. Each lane
//   takes the deltas when the tick is accepted, then classifies them and runs the
//   bit-serial percent ratio in two half-steps per bit of 100; ticks that skip the lanes
//   (locked, manual, disabled) go straight to the merge stage and ticks with trivial loads
//   leave the lanes after classification. One tick is in flight at a time: the next is
//   accepted only once the result of the last has been loaded into the output register.
// Reset:
//   aresetn (synchronous, active low) clears the stored counters, sets the interval
//   multiplier to 1 and loads the register defaults (20/60/35/90, automatic, enabled).
// Stall:
//   A finished result waits in the output register; the next tick is accepted
//   meanwhile and its result is held in the merge stage until the register frees up.
module load_based_core_hotplug_governor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lbhg_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lbhg_pkg::out_item_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbhg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbhg_pkg::CFG_DAT_W-1:0]      cfg_data
);

    lbhg_pkg::top_state_t state_reg, state_next;

    lbhg_pkg::cfg_t       cfg_reg, cfg_next;
    logic [2:0]           mult_reg, mult_next;
    logic                 online_reg;
    logic [21:0]          freq_reg;
    logic                 run_reg, run_next;
    logic                 run1_reg, run1_next;
    lbhg_pkg::out_item_t  out_reg;
    logic                 m_valid_reg, m_valid_next;

    logic                 s_accept;
    logic                 cfg_accept;
    logic                 use_lanes;
    logic                 start0;
    logic                 start1;
    logic                 lanes_idle;
    logic                 commit0;
    logic                 commit1;
    logic                 out_free;
    logic                 load_out;
    lbhg_pkg::lane_stat_t lane0_stat;
    lbhg_pkg::lane_stat_t lane1_stat;
    lbhg_pkg::out_item_t  merge_result;
    logic [2:0]           merge_mult;

    // Hold both input channels off while in reset
    assign s_ready    = aresetn && (state_reg == lbhg_pkg::TS_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = aresetn;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign use_lanes  = cfg_reg.governor_enabled && (cfg_reg.hotplug_mode == lbhg_pkg::MODE_AUTO)
                      && !cfg_reg.decision_freeze;
    assign start0     = s_accept && use_lanes;
    assign start1     = start0 && s_data.core1_online;
    assign lanes_idle = !lane0_stat.busy && !lane1_stat.busy;
    assign out_free   = !m_valid_reg || m_ready;

    // Lanes, one per core
    lbhg_lane u_lane0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start0),
        .commit     (commit0),
        .idle_count (s_data.idle_count_core0[lbhg_pkg::CNT_W-1:0]),
        .wall_count (s_data.wall_count_core0[lbhg_pkg::CNT_W-1:0]),
        .stat       (lane0_stat)
    );

    lbhg_lane u_lane1 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start1),
        .commit     (commit1),
        .idle_count (s_data.idle_count_core1[lbhg_pkg::CNT_W-1:0]),
        .wall_count (s_data.wall_count_core1[lbhg_pkg::CNT_W-1:0]),
        .stat       (lane1_stat)
    );

    lbhg_merge u_merge (
        .cfg       (cfg_reg),
        .online    (online_reg),
        .freq_khz  (freq_reg),
        .mult      (mult_reg),
        .lane0     (lane0_stat),
        .lane1     (lane1_stat),
        .result    (merge_result),
        .mult_next (merge_mult)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lbhg_pkg::TS_IDLE: begin
                if (s_accept) begin
                    state_next = use_lanes ? lbhg_pkg::TS_BUSY : lbhg_pkg::TS_MERGE;
                end
            end
            lbhg_pkg::TS_BUSY: begin
                if (lanes_idle) begin
                    state_next = lbhg_pkg::TS_MERGE;
                end
            end
            lbhg_pkg::TS_MERGE: begin
                if (out_free) begin
                    state_next = lbhg_pkg::TS_IDLE;
                end
            end
            default: state_next = lbhg_pkg::TS_IDLE;
        endcase
    end

    // Control outputs: commit counters of handled cores, load the result register
    always_comb begin
        commit0  = 1'b0;
        commit1  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            lbhg_pkg::TS_BUSY: begin
                commit0 = lanes_idle && run_reg;
                commit1 = lanes_idle && run1_reg && !lane0_stat.fail;
            end
            lbhg_pkg::TS_MERGE: begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // Tick bookkeeping and result handshake
    always_comb begin
        run_next     = run_reg;
        run1_next    = run1_reg;
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            run_next  = start0;
            run1_next = start1;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Configuration writes and interval multiplier
    always_comb begin
        cfg_next  = cfg_reg;
        mult_next = mult_reg;
        if (load_out) begin
            mult_next = merge_mult;
        end
        if (cfg_accept) begin
            case (cfg_index)
                lbhg_pkg::REG_LOAD_LOW:      cfg_next.load_low              = cfg_data;
                lbhg_pkg::REG_LOAD_HIGH:     cfg_next.load_high             = cfg_data;
                lbhg_pkg::REG_LOAD_LOW_OFF:  cfg_next.load_low_display_off  = cfg_data;
                lbhg_pkg::REG_LOAD_HIGH_OFF: cfg_next.load_high_display_off = cfg_data;
                lbhg_pkg::REG_DISPLAY_OFF:   cfg_next.display_off           = cfg_data[0];
                lbhg_pkg::REG_FREEZE:        cfg_next.decision_freeze       = cfg_data[0];
                lbhg_pkg::REG_HOTPLUG_MODE: begin
                    // leaving a manual mode restarts at the fast interval
                    if ((cfg_data[1:0] == lbhg_pkg::MODE_AUTO)
                        && (cfg_reg.hotplug_mode != lbhg_pkg::MODE_AUTO)) begin
                        mult_next = lbhg_pkg::MULT_FAST;
                    end
                    cfg_next.hotplug_mode = cfg_data[1:0];
                end
                lbhg_pkg::REG_GOV_ENABLED:   cfg_next.governor_enabled      = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                     <= lbhg_pkg::TS_IDLE;
            cfg_reg.load_low              <= 7'd20;
            cfg_reg.load_high             <= 7'd60;
            cfg_reg.load_low_display_off  <= 7'd35;
            cfg_reg.load_high_display_off <= 7'd90;
            cfg_reg.display_off           <= 1'b0;
            cfg_reg.decision_freeze       <= 1'b0;
            cfg_reg.hotplug_mode          <= lbhg_pkg::MODE_AUTO;
            cfg_reg.governor_enabled      <= 1'b1;
            mult_reg                      <= lbhg_pkg::MULT_FAST;
            run_reg                       <= 1'b0;
            run1_reg                      <= 1'b0;
            m_valid_reg                   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            mult_reg    <= mult_next;
            run_reg     <= run_next;
            run1_reg    <= run1_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_accept) begin
            online_reg <= s_data.core1_online;
            freq_reg   <= s_data.freq_khz;
        end
        if (load_out) begin
            out_reg <= merge_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // The multiplier only ever holds the fast or the slow interval
    a_mult_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (mult_reg == lbhg_pkg::MULT_FAST) || (mult_reg == lbhg_pkg::MULT_SLOW))
        else $error("interval multiplier out of range");

    // No tick is accepted while a lane still works on the previous one
    a_lanes_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> lanes_idle)
        else $error("tick accepted with a busy lane");

    // A valid sample always reschedules and never reports a load above 100
    a_sample_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.sample_valid) |->
            (m_data.reschedule && (m_data.average_load <= lbhg_pkg::LOAD_SCALE)))
        else $error("inconsistent valid sample");

    // Counters of core one are never stored when core zero failed
    a_commit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        commit1 |-> (commit0 && !lane0_stat.fail))
        else $error("core one counters stored without core zero");

endmodule

@@ sim/testbench.sv @@
// Testbench of the load-based core hotplug governor: scoreboard, stimulus and checking.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int ITEMS          = 1100;
    localparam int DRAIN_CYCLES   = 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    // Mode value 3 is not named in the package; the block treats it as manual on
    localparam logic [1:0] MODE_MAN_ON_ALT = 2'd3;

    localparam lbhg_pkg::cfg_t RESET_REGS = '{
        load_low:              7'd20,
        load_high:             7'd60,
        load_low_display_off:  7'd35,
        load_high_display_off: 7'd90,
        display_off:           1'b0,
        decision_freeze:       1'b0,
        hotplug_mode:          lbhg_pkg::MODE_AUTO,
        governor_enabled:      1'b1
    };

    // Predicts one decision per tick and checks the decisions that come back
    class decision_board;
        logic [63:0]         last_idle [2];
        logic [63:0]         last_wall [2];
        logic [2:0]          interval_mult;
        lbhg_pkg::cfg_t      regs;
        lbhg_pkg::out_item_t decisions_due [$];
        logic [1:0]          last_action;
        int                  fail_count;

        function new();
            foreach (last_idle[c]) begin
                last_idle[c] = '0;
                last_wall[c] = '0;
            end
            interval_mult = lbhg_pkg::MULT_FAST;
            regs          = RESET_REGS;
            last_action   = lbhg_pkg::ACT_NONE;
            fail_count    = 0;
        endfunction

        function int pending();
            return decisions_due.size();
        endfunction

        // Mirror one register write
        function void write_reg(logic [lbhg_pkg::CFG_IDX_W-1:0] idx,
                                logic [lbhg_pkg::CFG_DAT_W-1:0] val);
            case (idx)
                lbhg_pkg::REG_LOAD_LOW:      regs.load_low = val;
                lbhg_pkg::REG_LOAD_HIGH:     regs.load_high = val;
                lbhg_pkg::REG_LOAD_LOW_OFF:  regs.load_low_display_off = val;
                lbhg_pkg::REG_LOAD_HIGH_OFF: regs.load_high_display_off = val;
                lbhg_pkg::REG_DISPLAY_OFF:   regs.display_off = val[0];
                lbhg_pkg::REG_FREEZE:        regs.decision_freeze = val[0];
                lbhg_pkg::REG_HOTPLUG_MODE: begin
                    // leaving a manual mode drops back to the fast interval
                    if (val[1:0] == lbhg_pkg::MODE_AUTO &&
                        regs.hotplug_mode != lbhg_pkg::MODE_AUTO)
                        interval_mult = lbhg_pkg::MULT_FAST;
                    regs.hotplug_mode = val[1:0];
                end
                lbhg_pkg::REG_GOV_ENABLED:   regs.governor_enabled = val[0];
                default: ;
            endcase
        endfunction

        // Load of one core from its counter deltas; returns 0 when wall falls behind idle
        function bit core_load(int c, logic [63:0] idle, logic [63:0] wall,
                               output logic [lbhg_pkg::LOAD_W-1:0] load);
            logic [63:0] d_idle;
            logic [63:0] d_wall;
            logic [63:0] busy;
            logic [70:0] scaled;
            d_idle       = idle - last_idle[c];
            d_wall       = wall - last_wall[c];
            last_idle[c] = idle;
            last_wall[c] = wall;
            load         = '0;
            if (d_wall < d_idle)
                return 1'b0;
            if (d_wall != 0) begin
                busy   = d_wall - d_idle;
                scaled = {7'd0, busy} * 71'd100;
                load   = lbhg_pkg::LOAD_W'(scaled / {7'd0, d_wall});
            end
            return 1'b1;
        endfunction

        // Work out the decision of one accepted tick and queue it
        function void note_tick(lbhg_pkg::in_item_t t);
            lbhg_pkg::out_item_t         e;
            logic [lbhg_pkg::LOAD_W-1:0] load0;
            logic [lbhg_pkg::LOAD_W-1:0] load1;
            logic [lbhg_pkg::LOAD_W-1:0] lo;
            logic [lbhg_pkg::LOAD_W-1:0] hi;
            logic [lbhg_pkg::LOAD_W:0]   load_sum;
            bit                          ok;
            e     = '0;
            load0 = '0;
            load1 = '0;
            if (!regs.governor_enabled) begin
                // stopped: nothing happens
            end else if (regs.hotplug_mode != lbhg_pkg::MODE_AUTO) begin
                if (regs.hotplug_mode == lbhg_pkg::MODE_MAN_OFF && t.core1_online)
                    e.action = lbhg_pkg::ACT_DOWN;
            end else if (regs.decision_freeze) begin
                e.reschedule = 1'b1;
            end else begin
                e.reschedule = 1'b1;
                ok = core_load(0, t.idle_count_core0, t.wall_count_core0, load0);
                if (ok && t.core1_online)
                    ok = core_load(1, t.idle_count_core1, t.wall_count_core1, load1);
                if (ok) begin
                    lo = regs.display_off ? regs.load_low_display_off : regs.load_low;
                    hi = regs.display_off ? regs.load_high_display_off : regs.load_high;
                    load_sum = {1'b0, load0} + {1'b0, load1};
                    e.average_load = t.core1_online ? load_sum[lbhg_pkg::LOAD_W:1] : load0;
                    e.sample_valid = 1'b1;
                    if (t.core1_online &&
                        (e.average_load < lo || t.freq_khz <= lbhg_pkg::FREQ_FLOOR_KHZ)) begin
                        e.action      = lbhg_pkg::ACT_DOWN;
                        interval_mult = lbhg_pkg::MULT_FAST;
                    end else if (!t.core1_online && e.average_load > hi &&
                                 t.freq_khz > lbhg_pkg::FREQ_FLOOR_KHZ) begin
                        e.action      = lbhg_pkg::ACT_UP;
                        interval_mult = lbhg_pkg::MULT_SLOW;
                    end
                end
                e.load_core0 = load0;
                e.load_core1 = load1;
            end
            e.next_interval = interval_mult;
            last_action     = e.action;
            decisions_due.push_back(e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
                fail_count++;
            end
        endfunction

        // Compare one returned decision with the oldest prediction
        function void check_decision(lbhg_pkg::out_item_t got);
            lbhg_pkg::out_item_t e;
            if (decisions_due.size() == 0) begin
                $display("%0t: unexpected decision, expected none, actual %h", $time, got);
                fail_count++;
                return;
            end
            e = decisions_due.pop_front();
            compare_field("action", e.action, got.action);
            compare_field("reschedule", e.reschedule, got.reschedule);
            compare_field("next_interval", e.next_interval, got.next_interval);
            compare_field("average_load", e.average_load, got.average_load);
            compare_field("load_core0", e.load_core0, got.load_core0);
            compare_field("load_core1", e.load_core1, got.load_core1);
            compare_field("sample_valid", e.sample_valid, got.sample_valid);
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lbhg_pkg::in_item_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lbhg_pkg::out_item_t            m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lbhg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lbhg_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    decision_board board;

    // Counters the next tick builds on, and the online flag it reports
    logic [63:0] cnt_idle [2] = '{64'd0, 64'd0};
    logic [63:0] cnt_wall [2] = '{64'd0, 64'd0};
    logic        core1_up     = 1'b0;

    int send_idle_pct = 22;
    int recv_idle_pct = 58;
    bit hold_go       = 1'b0;
    int hold_left     = HOLD_CYCLES;
    int quiet_cycles  = 0;

    load_based_core_hotplug_governor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // Drive result ready: one long hold-off when requested, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_go && hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_decision(m_data);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one tick with absolute counters and note it once accepted
    task automatic send_tick(input logic [63:0] i0, input logic [63:0] w0,
                             input logic [63:0] i1, input logic [63:0] w1,
                             input logic online, input logic [21:0] freq);
        lbhg_pkg::in_item_t t;
        t.idle_count_core0 = i0;
        t.wall_count_core0 = w0;
        t.idle_count_core1 = i1;
        t.wall_count_core1 = w1;
        t.core1_online     = online;
        t.freq_khz         = freq;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(t);
        cnt_idle[0] = i0;
        cnt_wall[0] = w0;
        cnt_idle[1] = i1;
        cnt_wall[1] = w1;
    endtask

    // Offer one tick whose counters advance by the given deltas
    task automatic tick_delta(input logic [63:0] di0, input logic [63:0] dw0,
                              input logic [63:0] di1, input logic [63:0] dw1,
                              input logic online, input logic [21:0] freq);
        send_tick(cnt_idle[0] + di0, cnt_wall[0] + dw0, cnt_idle[1] + di1,
                  cnt_wall[1] + dw1, online, freq);
    endtask

    // Mostly plausible counter growth, with zero, huge, backward and garbage samples mixed in
    task automatic random_tick();
        logic [63:0] nxt_idle [2];
        logic [63:0] nxt_wall [2];
        logic [63:0] dw;
        logic [63:0] di;
        logic [21:0] freq;
        int          pick;
        for (int c = 0; c < 2; c++) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                dw = 64'($urandom_range(1, 1000000));
                di = dw * 64'($urandom_range(0, 100)) / 64'd100;
            end else if (pick < 82) begin
                dw = 64'($urandom_range(0, 3));
                di = dw;
            end else if (pick < 88) begin
                dw = {$urandom, $urandom};
                di = {$urandom, $urandom} & dw;
            end else begin
                dw = 64'($urandom_range(0, 1000));
                di = dw + 64'($urandom_range(1, 1000));
            end
            nxt_idle[c] = cnt_idle[c] + di;
            nxt_wall[c] = cnt_wall[c] + dw;
            if (pick >= 95) begin
                nxt_idle[c] = {$urandom, $urandom};
                nxt_wall[c] = {$urandom, $urandom};
            end
        end
        pick = $urandom_range(99);
        if (pick < 80)
            freq = 22'($urandom_range(int'(lbhg_pkg::FREQ_FLOOR_KHZ) + 1, 4194303));
        else if (pick < 90)
            freq = 22'($urandom_range(0, int'(lbhg_pkg::FREQ_FLOOR_KHZ)));
        else if (pick < 95)
            freq = lbhg_pkg::FREQ_FLOOR_KHZ;
        else
            freq = lbhg_pkg::FREQ_FLOOR_KHZ + 22'd1;
        // follow the last decision, as the platform would, with the odd surprise
        if (board.last_action == lbhg_pkg::ACT_UP)
            core1_up = 1'b1;
        else if (board.last_action == lbhg_pkg::ACT_DOWN)
            core1_up = 1'b0;
        if ($urandom_range(99) < 8)
            core1_up = ~core1_up;
        send_tick(nxt_idle[0], nxt_wall[0], nxt_idle[1], nxt_wall[1], core1_up, freq);
    endtask

    task automatic write_reg(input logic [lbhg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lbhg_pkg::CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
    endtask

    // Wait until the block is idle, then write all registers; narrow ones get junk upper bits
    task automatic program_regs(input lbhg_pkg::cfg_t c);
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(lbhg_pkg::REG_LOAD_LOW, c.load_low);
        write_reg(lbhg_pkg::REG_LOAD_HIGH, c.load_high);
        write_reg(lbhg_pkg::REG_LOAD_LOW_OFF, c.load_low_display_off);
        write_reg(lbhg_pkg::REG_LOAD_HIGH_OFF, c.load_high_display_off);
        write_reg(lbhg_pkg::REG_DISPLAY_OFF, {6'($urandom_range(0, 63)), c.display_off});
        write_reg(lbhg_pkg::REG_FREEZE, {6'($urandom_range(0, 63)), c.decision_freeze});
        write_reg(lbhg_pkg::REG_HOTPLUG_MODE, {5'($urandom_range(0, 31)), c.hotplug_mode});
        write_reg(lbhg_pkg::REG_GOV_ENABLED,
                  {6'($urandom_range(0, 63)), c.governor_enabled});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        lbhg_pkg::cfg_t regs;
        int             ticks_sent;
        int             phase;
        int             count;
        bit             deep;

        board      = new();
        ticks_sent = 0;
        phase      = 0;

        // Hold reset, then release it once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks under the reset settings
        // zero wall delta on the very first sample
        tick_delta(64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 22'd1000000);
        // fully busy core zero brings core one up
        tick_delta(64'd0, 64'd1000, 64'd0, 64'd0, 1'b0, 22'd1000000);
        // both online, loads 50 and 70
        tick_delta(64'd500, 64'd1000, 64'd300, 64'd1000, 1'b1, 22'd1000000);
        // frequency at the floor forces core one down
        tick_delta(64'd100, 64'd1000, 64'd100, 64'd1000, 1'b1, lbhg_pkg::FREQ_FLOOR_KHZ);
        // light load takes core one down
        tick_delta(64'd900, 64'd1000, 64'd950, 64'd1000, 1'b1, 22'd1000000);
        // wall behind idle on core zero aborts the sample
        tick_delta(64'd2000, 64'd1000, 64'd10, 64'd100, 1'b1, 22'd1000000);
        // wall behind idle on core one aborts after core zero
        tick_delta(64'd0, 64'd1000, 64'd2000, 64'd1000, 1'b1, 22'd1000000);
        // idle equal to wall
        tick_delta(64'd777, 64'd777, 64'd5, 64'd5, 1'b1, 22'd1000000);
        // average right on the take-down threshold keeps core one
        tick_delta(64'd800, 64'd1000, 64'd80, 64'd100, 1'b1, 22'd1000000);
        // load right on the bring-up threshold does nothing
        tick_delta(64'd40, 64'd100, 64'd0, 64'd0, 1'b0, 22'd1000000);
        // frequency just above the floor with full load
        tick_delta(64'd0, 64'd100, 64'd0, 64'd0, 1'b0, lbhg_pkg::FREQ_FLOOR_KHZ + 22'd1);
        // full load at zero frequency does not bring core one up
        tick_delta(64'd0, 64'd100, 64'd0, 64'd0, 1'b0, 22'd0);
        // widest deltas: the percent product needs more than 64 bits
        tick_delta(64'd1, '1, 64'h8000_0000_0000_0000, '1, 1'b1, 22'h3FFFFF);
        tick_delta(64'h0123_4567_89AB_CDEF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd3, '1, 1'b1,
                   22'd3000000);
        // deltas that wrap the counters
        tick_delta(64'd10, 64'd100, 64'd3, 64'd7, 1'b1, 22'd3000000);
        // all counter bits set, then all clear
        send_tick('1, '1, '1, '1, 1'b1, 22'h3FFFFF);
        send_tick('0, '0, '0, '0, 1'b0, 22'h0);
        // odd ratios
        tick_delta(64'd1, 64'd3, 64'd2, 64'd3, 1'b1, 22'd1000000);
        tick_delta(64'd1, 64'd7, 64'd6, 64'd7, 1'b0, 22'd1000000);
        s_valid <= 1'b0;

        // Phases of register settings, each followed by ticks
        while (ticks_sent < ITEMS) begin
            regs = RESET_REGS;
            case (phase)
                0: ;
                1: regs.display_off = 1'b1;
                2: begin
                    regs.load_low  = 7'd0;
                    regs.load_high = 7'd127;
                end
                3: begin
                    regs.load_low  = 7'd127;
                    regs.load_high = 7'd0;
                end
                4: begin
                    regs.display_off           = 1'b1;
                    regs.load_low_display_off  = 7'd100;
                    regs.load_high_display_off = 7'd0;
                end
                5: regs.decision_freeze = 1'b1;
                6: regs.hotplug_mode = lbhg_pkg::MODE_MAN_ON;
                7: regs.hotplug_mode = lbhg_pkg::MODE_MAN_OFF;
                8: regs.hotplug_mode = MODE_MAN_ON_ALT;
                9: ;
                10: begin
                    regs.governor_enabled = 1'b0;
                    regs.hotplug_mode     = lbhg_pkg::MODE_MAN_OFF;
                end
                11: begin
                    regs.decision_freeze = 1'b1;
                    regs.hotplug_mode    = lbhg_pkg::MODE_MAN_OFF;
                end
                default: begin
                    if ($urandom_range(9) == 0) begin
                        regs.load_low              = 7'($urandom_range(0, 127));
                        regs.load_high             = 7'($urandom_range(0, 127));
                        regs.load_low_display_off  = 7'($urandom_range(0, 127));
                        regs.load_high_display_off = 7'($urandom_range(0, 127));
                    end else begin
                        regs.load_low              = 7'($urandom_range(0, 60));
                        regs.load_high             = 7'($urandom_range(regs.load_low, 100));
                        regs.load_low_display_off  = 7'($urandom_range(0, 60));
                        regs.load_high_display_off =
                            7'($urandom_range(regs.load_low_display_off, 100));
                    end
                    regs.display_off      = 1'($urandom_range(1));
                    regs.decision_freeze  = ($urandom_range(99) < 8);
                    regs.hotplug_mode     = ($urandom_range(99) < 85) ? lbhg_pkg::MODE_AUTO
                                                                      : 2'($urandom_range(1, 3));
                    regs.governor_enabled = ($urandom_range(99) < 92);
                end
            endcase
            program_regs(regs);

            // sender and receiver idle patterns shift as the run goes on
            if (ticks_sent < ITEMS / 3) begin
                send_idle_pct = 22;
                recv_idle_pct = 58;
            end else if (ticks_sent < 2 * ITEMS / 3) begin
                send_idle_pct = 58;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // halfway through, hold the receiver off while ticks keep coming
            if (!hold_go && ticks_sent >= ITEMS / 2)
                hold_go = 1'b1;

            deep  = regs.governor_enabled && regs.hotplug_mode == lbhg_pkg::MODE_AUTO
                    && !regs.decision_freeze;
            count = deep ? 70 : 15;
            repeat (count) random_tick();
            s_valid <= 1'b0;
            ticks_sent += count;
            phase++;
        end

        // Drain, then allow time for anything stray
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lbhg_pkg.sv
rtl/lbhg_lane.sv
rtl/lbhg_merge.sv
rtl/load_based_core_hotplug_governor.sv
sim/testbench.sv
